// ===== sv/pdrr_pkg.sv =====
package pdrr_pkg;

  // Field widths fixed by the interface.
  localparam int REDUCE_W = 5;
  localparam int DIM_W    = 13;
  localparam int ROW_W    = 12;
  localparam int COORD_W  = 16;
  localparam int EXT_W    = 17;
  localparam int COLOR_W  = 32;
  localparam int INDEX_W  = 2;

  // Register indexes on the configuration port.
  localparam logic [INDEX_W-1:0] REG_REDUCE_FACTOR = 2'd0;
  localparam logic [INDEX_W-1:0] REG_ROW_WIDTH     = 2'd1;
  localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT  = 2'd2;

  // Limits and reset values.
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_FACTOR = 16;
  localparam logic [REDUCE_W-1:0] FACTOR_RESET = 5'd1;
  localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd4096;
  localparam logic [DIM_W-1:0]    HEIGHT_RESET = 13'd4096;
  localparam logic [COLOR_W-1:0]  RED_OPAQUE   = 32'hFFFF0000;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // One finished run, in reduced coordinates, with its colour.
  typedef struct packed {
    logic [COORD_W-1:0] start_col;
    logic [ROW_W-1:0]   row;
    logic [EXT_W-1:0]   run_len;
    logic [COLOR_W-1:0] color;
  } run_rec_t;

  // Status of the run queue.
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

// ===== sv/pdrr_front.sv =====
module pdrr_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [pdrr_pkg::COLOR_W-1:0]   pixel_a,
  input  logic [pdrr_pkg::COLOR_W-1:0]   pixel_b,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] width_eff,
  input  logic [pdrr_pkg::DIM_W-1:0]     height_eff,
  output logic                           emit,
  output pdrr_pkg::run_rec_t             rec
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LEN_W = $clog2(MAX_WIDTH + 1);

  logic                          run_active;
  logic [COL_W-1:0]              run_start_col;
  logic [LEN_W-1:0]              run_length;
  logic [COL_W-1:0]              column_count;
  logic [pdrr_pkg::ROW_W-1:0]    row_count;
  logic [pdrr_pkg::COLOR_W-1:0]  next_color;

  logic                          differs;
  logic                          last_col;
  logic                          last_row;
  logic [COL_W-1:0]              cur_start;
  logic [LEN_W-1:0]              cur_len;

  // Classify the pixel pair and its place in the frame.
  always_comb begin
    differs   = (pixel_a ^ pixel_b) != '0;
    last_col  = (LEN_W'(column_count) + LEN_W'(1)) >= width_eff;
    last_row  = ({1'b0, row_count} + pdrr_pkg::DIM_W'(1)) >= height_eff;
    cur_start = run_active ? run_start_col : column_count;
    cur_len   = differs ? ((run_active ? run_length : '0) + LEN_W'(1)) : run_length;
    emit      = differs ? last_col : run_active;
  end

  // The run handed to the queue when it ends.
  always_comb begin
    rec.start_col = pdrr_pkg::COORD_W'(cur_start);
    rec.row       = row_count;
    rec.run_len   = pdrr_pkg::EXT_W'(cur_len);
    rec.color     = next_color;
  end

  // Run tracking, counters and colour rotation.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active    <= 1'b0;
      run_start_col <= '0;
      run_length    <= '0;
      column_count  <= '0;
      row_count     <= '0;
      next_color    <= pdrr_pkg::RED_OPAQUE;
    end else if (accept) begin
      if (emit) begin
        run_active    <= 1'b0;
        run_start_col <= '0;
        run_length    <= '0;
      end else if (differs) begin
        run_active    <= 1'b1;
        run_start_col <= cur_start;
        run_length    <= cur_len;
      end

      if (last_col && last_row) begin
        next_color <= pdrr_pkg::RED_OPAQUE;
      end else if (emit) begin
        next_color <= {next_color[23:0], next_color[31:24]};
      end

      if (last_col) begin
        column_count <= '0;
        if (last_row) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + pdrr_pkg::ROW_W'(1);
        end
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

endmodule

// ===== sv/pdrr_queue.sv =====
module pdrr_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  pdrr_pkg::run_rec_t   wr_data,
  input  logic                 rd,
  output pdrr_pkg::run_rec_t   rd_data,
  output pdrr_pkg::q_status_t  status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pdrr_pkg::run_rec_t store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  always_comb begin
    status.full  = count == CNT_W'(DEPTH);
    status.valid = count != '0;
    rd_data      = store[rd_ptr];
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/pdrr_back.sv =====
module pdrr_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [pdrr_pkg::REDUCE_W-1:0]   factor,
  input  logic                            q_valid,
  input  pdrr_pkg::run_rec_t              q_data,
  output logic                            q_rd,
  output logic                            empty,
  input  logic                            pop,
  output logic [pdrr_pkg::COORD_W-1:0]    rect_left,
  output logic [pdrr_pkg::COORD_W-1:0]    rect_top,
  output logic [pdrr_pkg::EXT_W-1:0]      rect_width,
  output logic [pdrr_pkg::REDUCE_W-1:0]   rect_height,
  output logic [pdrr_pkg::COLOR_W-1:0]    fill_color
);

  localparam int LEFT_P_W  = pdrr_pkg::COORD_W + pdrr_pkg::REDUCE_W;
  localparam int TOP_P_W   = pdrr_pkg::ROW_W + pdrr_pkg::REDUCE_W;
  localparam int WIDTH_P_W = pdrr_pkg::EXT_W + pdrr_pkg::REDUCE_W;

  logic                  out_valid;
  logic                  load;
  logic [LEFT_P_W-1:0]   left_p;
  logic [TOP_P_W-1:0]    top_p;
  logic [WIDTH_P_W-1:0]  width_p;

  // Scale the run back to full resolution.
  always_comb begin
    left_p  = LEFT_P_W'(q_data.start_col) * LEFT_P_W'(factor);
    top_p   = TOP_P_W'(q_data.row) * TOP_P_W'(factor);
    width_p = WIDTH_P_W'(q_data.run_len) * WIDTH_P_W'(factor);
    load    = q_valid && (!out_valid || pop);
    q_rd    = load;
    empty   = !out_valid;
  end

  // Output register: refilled when empty or when its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rect_left   <= left_p[pdrr_pkg::COORD_W-1:0];
      rect_top    <= top_p[pdrr_pkg::COORD_W-1:0];
      rect_width  <= width_p[pdrr_pkg::EXT_W-1:0];
      rect_height <= factor;
      fill_color  <= q_data.color;
    end
  end

endmodule

// ===== sv/pixel_diff_run_rectangles_top.sv =====
// Pixel difference run rectangles.
//
// Input channel: one beat carries a pixel pair (pixel_a, pixel_b) of two
// reduced images in raster order; it is taken when push is high and full is
// low. Result channel: while empty is low the oldest rectangle is on the
// rect_* and fill_color ports, and pop takes it. Configuration: the user
// must write reduce_factor, row_width and frame_height through cfg_write,
// cfg_index and cfg_data only while idle, which the block does not enforce.
//
// Throughput is one pixel pair per clock while full is low. A rectangle
// passes through the run queue and then the output register, where it is
// scaled by the reduction factor.
// When the receiver stalls, finished runs collect in the two-entry run queue
// and the output register; full rises once the queue is full, because the
// next pixel could end another run.
// Reset empties the run queue and output register, clears the counters and
// run tracker, and sets colour opaque red, factor 1 and frame 4096 by 4096.
module pixel_diff_run_rectangles_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [pdrr_pkg::COLOR_W-1:0]    pixel_a,
  input  logic [pdrr_pkg::COLOR_W-1:0]    pixel_b,
  output logic                            empty,
  input  logic                            pop,
  output logic [pdrr_pkg::COORD_W-1:0]    rect_left,
  output logic [pdrr_pkg::COORD_W-1:0]    rect_top,
  output logic [pdrr_pkg::EXT_W-1:0]      rect_width,
  output logic [pdrr_pkg::REDUCE_W-1:0]   rect_height,
  output logic [pdrr_pkg::COLOR_W-1:0]    fill_color,
  input  logic                            cfg_write,
  input  logic [pdrr_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [pdrr_pkg::DIM_W-1:0]      cfg_data
);

  localparam int LEN_W = $clog2(MAX_WIDTH + 1);

  logic [pdrr_pkg::REDUCE_W-1:0] reduce_factor;
  logic [pdrr_pkg::DIM_W-1:0]    row_width;
  logic [pdrr_pkg::DIM_W-1:0]    frame_height;

  logic [pdrr_pkg::REDUCE_W-1:0] factor_eff;
  logic [LEN_W-1:0]              width_eff;
  logic [pdrr_pkg::DIM_W-1:0]    height_eff;

  logic                          accept;
  logic                          q_push;
  logic                          q_rd;
  pdrr_pkg::run_rec_t            rec;
  pdrr_pkg::run_rec_t            q_data;
  pdrr_pkg::q_status_t           q_stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_factor <= pdrr_pkg::FACTOR_RESET;
      row_width     <= pdrr_pkg::WIDTH_RESET;
      frame_height  <= pdrr_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pdrr_pkg::REG_REDUCE_FACTOR: reduce_factor <= cfg_data[pdrr_pkg::REDUCE_W-1:0];
        pdrr_pkg::REG_ROW_WIDTH:     row_width     <= cfg_data;
        pdrr_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Out-of-range settings are clamped to the nearest legal value.
  always_comb begin
    if (reduce_factor == '0) begin
      factor_eff = pdrr_pkg::REDUCE_W'(1);
    end else if (32'(reduce_factor) > 32'(pdrr_pkg::MAX_FACTOR)) begin
      factor_eff = pdrr_pkg::REDUCE_W'(pdrr_pkg::MAX_FACTOR);
    end else begin
      factor_eff = reduce_factor;
    end

    if (row_width == '0) begin
      width_eff = LEN_W'(1);
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      width_eff = LEN_W'(MAX_WIDTH);
    end else begin
      width_eff = LEN_W'(row_width);
    end

    if (frame_height == '0) begin
      height_eff = pdrr_pkg::DIM_W'(1);
    end else if (32'(frame_height) > 32'(pdrr_pkg::MAX_HEIGHT)) begin
      height_eff = pdrr_pkg::DIM_W'(pdrr_pkg::MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  // A pixel is taken only when the run queue has room for a result.
  always_comb begin
    full   = q_stat.full;
    accept = push && !q_stat.full;
  end

  pdrr_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pixel_a   (pixel_a),
    .pixel_b   (pixel_b),
    .width_eff (width_eff),
    .height_eff(height_eff),
    .emit      (q_push),
    .rec       (rec)
  );

  pdrr_queue #(
    .DEPTH(pdrr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push && accept),
    .wr_data(rec),
    .rd     (q_rd),
    .rd_data(q_data),
    .status (q_stat)
  );

  pdrr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .factor     (factor_eff),
    .q_valid    (q_stat.valid),
    .q_data     (q_data),
    .q_rd       (q_rd),
    .empty      (empty),
    .pop        (pop),
    .rect_left  (rect_left),
    .rect_top   (rect_top),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .fill_color (fill_color)
  );

  // A finished run written to the queue is waiting there in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    ($past(q_push && accept) && !$past(rst)) |-> q_stat.valid)
    else $error("run written to the queue was lost");

  // The back part reads the queue only when it holds an entry.
  assert property (@(posedge clk) disable iff (rst)
    q_rd |-> q_stat.valid)
    else $error("run queue read while empty");

  // A waiting rectangle always carries a legal height.
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (rect_height != '0 &&
                32'(rect_height) <= 32'(pdrr_pkg::MAX_FACTOR)))
    else $error("rectangle height out of range");

endmodule
